// ===== hdl/dwhd_pkg.sv =====
`default_nettype none

package dwhd_pkg;

  // Number of character lanes that work side by side on one word.
  localparam int LANES = 4;
  // Width of the running mismatch count.
  localparam int COUNT_BITS = 24;
  // Width of one ASCII character and of the character fields of a word.
  localparam int CHAR_BITS = 8;
  localparam int CHARS_BITS = 32;
  // Width of the number of mismatches found in one word.
  localparam int MISM_BITS = $clog2(LANES + 1);

  typedef struct packed {
    logic [CHARS_BITS-1:0] chars_a;
    logic [CHARS_BITS-1:0] chars_b;
    logic [2:0]            lanes_valid;
    logic                  last;
  } item_word_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] distance;
    logic                  saturated;
  } result_word_t;

endpackage

`default_nettype wire

// ===== hdl/dna_wildcard_hamming_distance_top.sv =====
`default_nettype none

// Wildcard Hamming distance over two aligned DNA sequences. Each input word
// carries four ASCII characters of sequence A and four of sequence B (lane 0
// in the low byte), the number of low lanes that hold real characters, and a
// flag marking the final word of the sequence pair. Each lane maps its two
// characters to one-hot nucleotide codes (A, C, G, T one bit each, a dash is
// a wildcard that matches any base, any other byte matches nothing) and flags
// a mismatch when the codes share no bit. A merging stage adds the lane flags
// into a 24-bit running count that saturates at its maximum and remembers that
// it did. On the word marked last the total and the saturation flag leave as
// one result word and the count starts over from zero; other words give no
// result. The block takes one word every cycle: the lane compare and the
// count update happen in the same cycle, and the result sits in an output
// register, so a result appears in the cycle after its last word is accepted.
// The input is stalled only while that output register holds a result that
// the downstream side is stalling.

module dna_wildcard_hamming_distance_top (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire dwhd_pkg::item_word_t   item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output dwhd_pkg::result_word_t      result
);

  logic [dwhd_pkg::LANES-1:0] lane_mismatch;
  logic                       accept;

  // The output register is the only place a word can wait.
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  for (genvar i = 0; i < dwhd_pkg::LANES; i++) begin : g_lane
    logic [dwhd_pkg::CHAR_BITS-1:0] char_a;
    logic [dwhd_pkg::CHAR_BITS-1:0] char_b;
    logic                           enable;

    // Lanes past the width of the character fields read as an invalid byte.
    if ((i + 1) * dwhd_pkg::CHAR_BITS <= dwhd_pkg::CHARS_BITS) begin : g_char
      assign char_a = item.chars_a[i*dwhd_pkg::CHAR_BITS +: dwhd_pkg::CHAR_BITS];
      assign char_b = item.chars_b[i*dwhd_pkg::CHAR_BITS +: dwhd_pkg::CHAR_BITS];
    end else begin : g_zero
      assign char_a = '0;
      assign char_b = '0;
    end

    // A lane counts only when it lies below the number of valid lanes.
    assign enable = int'(item.lanes_valid) > i;

    dwhd_lane u_lane (
      .char_a   (char_a),
      .char_b   (char_b),
      .enable   (enable),
      .mismatch (lane_mismatch[i])
    );
  end

  dwhd_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .mismatch     (lane_mismatch),
    .last         (item.last),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== hdl/dwhd_lane.sv =====
`default_nettype none

module dwhd_lane (
  input  wire logic [dwhd_pkg::CHAR_BITS-1:0] char_a,
  input  wire logic [dwhd_pkg::CHAR_BITS-1:0] char_b,
  input  wire logic                           enable,
  output logic                                mismatch
);

  localparam logic [7:0] CHAR_GAP = 8'h2d;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_C   = 8'h43;
  localparam logic [7:0] CHAR_G   = 8'h47;
  localparam logic [7:0] CHAR_T   = 8'h54;

  localparam logic [3:0] CODE_GAP  = 4'b1111;
  localparam logic [3:0] CODE_A    = 4'b0001;
  localparam logic [3:0] CODE_C    = 4'b0010;
  localparam logic [3:0] CODE_G    = 4'b0100;
  localparam logic [3:0] CODE_T    = 4'b1000;
  localparam logic [3:0] CODE_NONE = 4'b0000;

  // One-hot nucleotide code; a gap matches every base, anything else nothing.
  function automatic logic [3:0] encode(input logic [7:0] ch);
    logic [3:0] code;
    unique case (ch)
      CHAR_GAP: code = CODE_GAP;
      CHAR_A:   code = CODE_A;
      CHAR_C:   code = CODE_C;
      CHAR_G:   code = CODE_G;
      CHAR_T:   code = CODE_T;
      default:  code = CODE_NONE;
    endcase
    return code;
  endfunction

  logic [3:0] code_a;
  logic [3:0] code_b;

  always_comb begin
    code_a   = encode(char_a);
    code_b   = encode(char_b);
    mismatch = enable && ((code_a & code_b) == CODE_NONE);
  end

endmodule

`default_nettype wire

// ===== hdl/dwhd_merge.sv =====
`default_nettype none

module dwhd_merge (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic [dwhd_pkg::LANES-1:0]    mismatch,
  input  wire logic                          last,
  input  wire logic                          result_stall,
  output logic                               result_valid,
  output dwhd_pkg::result_word_t             result
);

  logic [dwhd_pkg::MISM_BITS-1:0]  pop;
  logic [dwhd_pkg::COUNT_BITS:0]   sum;
  logic [dwhd_pkg::COUNT_BITS-1:0] count;
  logic [dwhd_pkg::COUNT_BITS-1:0] count_next;
  logic                            overflow;
  logic                            overflow_next;

  always_comb begin
    pop = '0;
    for (int i = 0; i < dwhd_pkg::LANES; i++) begin
      pop = pop + dwhd_pkg::MISM_BITS'(mismatch[i]);
    end
    sum = {1'b0, count} + (dwhd_pkg::COUNT_BITS + 1)'(pop);
    // A carry out means the true count passed the maximum, so it sticks there.
    count_next    = sum[dwhd_pkg::COUNT_BITS] ? '1 : sum[dwhd_pkg::COUNT_BITS-1:0];
    overflow_next = overflow | sum[dwhd_pkg::COUNT_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      overflow     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        if (last) begin
          count           <= '0;
          overflow        <= 1'b0;
          result_valid    <= 1'b1;
          result.distance  <= count_next;
          result.saturated <= overflow_next;
        end else begin
          count    <= count_next;
          overflow <= overflow_next;
        end
      end
    end
  end

endmodule

`default_nettype wire
